FILE: src/kpas_pkg.sv
// Shared types, sizes and codes of the keypad PIN authentication sequencer.
package kpas_pkg;

    localparam int ID_DIGITS  = 8;
    localparam int PIN_DIGITS = 8;

    localparam int ID_IDX_W   = (ID_DIGITS > 1) ? $clog2(ID_DIGITS) : 1;
    localparam int PIN_IDX_W  = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;
    localparam int ID_LEN_W   = $clog2(ID_DIGITS + 1);
    localparam int PIN_LEN_W  = $clog2(PIN_DIGITS + 1);
    localparam int FOLD_N     = (ID_DIGITS > PIN_DIGITS) ? ID_DIGITS : PIN_DIGITS;
    localparam int FOLD_W     = (FOLD_N > 1) ? $clog2(FOLD_N) : 1;

    localparam int DIGIT_W    = 4;
    localparam int ID_VALUE_W = 27;
    localparam int PIN_BCD_W  = 32;
    localparam int COUNT_W    = 4;
    localparam int CFG_W      = 16;
    localparam int TIMER_W    = 32;
    localparam int ACC_W      = 10;
    localparam int SUM_W      = 17;
    localparam int SECS_W     = 8;
    localparam int DIV_SHIFT  = 27;
    localparam int RECIP_W    = 18;
    localparam int PROD_W     = SUM_W + RECIP_W;

    localparam logic [ACC_W-1:0]   MS_PER_S  = 10'd1000;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 18'd134218;

    localparam logic [7:0] KEY_STAR = 8'h2A;
    localparam logic [7:0] KEY_HASH = 8'h23;
    localparam logic [7:0] KEY_ZERO = 8'h30;
    localparam logic [7:0] KEY_NINE = 8'h39;

    typedef logic [DIGIT_W-1:0] t_digit;

    typedef enum logic [1:0] {
        OP_KEY  = 2'd0,
        OP_RESP = 2'd1,
        OP_TICK = 2'd2,
        OP_LINK = 2'd3
    } t_op;

    typedef logic [2:0] t_phase;
    localparam t_phase PH_ID      = 3'd0;
    localparam t_phase PH_PIN     = 3'd1;
    localparam t_phase PH_AUTH    = 3'd2;
    localparam t_phase PH_OFFLINE = 3'd3;
    localparam t_phase PH_SUCCESS = 3'd4;
    localparam t_phase PH_BAD_PIN = 3'd5;
    localparam t_phase PH_LOCKED  = 3'd6;
    localparam t_phase PH_NOTFND  = 3'd7;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD_PIN = 3'd1;
    localparam logic [2:0] ST_LOCKED  = 3'd2;
    localparam logic [2:0] ST_NOTFND  = 3'd3;

    localparam logic [1:0] CFG_AUTH_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_SUCCESS_SHOW = 2'd1;
    localparam logic [1:0] CFG_MESSAGE_SHOW = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } t_fold_stat;

    typedef struct packed {
        t_op         op;
        logic [7:0]  key;
        logic [2:0]  status;
        logic [7:0]  attempts;
        logic [15:0] lock_s;
        logic [15:0] elapsed;
        logic        link;
    } t_item;

endpackage

FILE: src/kpas_fold.sv
// Digit fold unit: one id digit and one PIN digit per cycle into value and BCD.
module kpas_fold (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [kpas_pkg::ID_LEN_W-1:0]     i_id_len,
    input  logic [kpas_pkg::PIN_LEN_W-1:0]    i_pin_len,
    input  kpas_pkg::t_digit                  i_id_digit,
    input  kpas_pkg::t_digit                  i_pin_digit,
    output logic [kpas_pkg::FOLD_W-1:0]       o_idx,
    output kpas_pkg::t_fold_stat              o_stat,
    output logic [kpas_pkg::ID_VALUE_W-1:0]   o_id_value,
    output logic [kpas_pkg::PIN_BCD_W-1:0]    o_pin_bcd
);
    import kpas_pkg::*;

    logic [FOLD_W-1:0]     r_idx;
    logic                  r_busy;
    logic                  r_done;
    logic [ID_VALUE_W-1:0] r_idv;
    logic [PIN_BCD_W-1:0]  r_pinv;

    logic                  id_take;
    logic                  pin_take;
    logic                  last;
    logic [ID_VALUE_W-1:0] n_idv;
    logic [PIN_BCD_W-1:0]  n_pinv;

    assign id_take  = int'(r_idx) < int'(i_id_len);
    assign pin_take = int'(r_idx) < int'(i_pin_len);
    assign last     = r_idx == FOLD_W'(FOLD_N - 1);

    assign n_idv  = (r_idv << 3) + (r_idv << 1) + ID_VALUE_W'(i_id_digit);
    assign n_pinv = {r_pinv[PIN_BCD_W-DIGIT_W-1:0], i_pin_digit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy) begin
                r_idx <= r_idx + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_idv  <= '0;
            r_pinv <= '0;
        end else if (r_busy) begin
            if (id_take) begin
                r_idv <= n_idv;
            end
            if (pin_take) begin
                r_pinv <= n_pinv;
            end
        end
    end

    assign o_idx       = r_idx;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_id_value  = r_idv;
    assign o_pin_bcd   = r_pinv;

endmodule

FILE: src/keypad_pin_auth_sequencer_top.sv
// Top level of the keypad PIN authentication sequencer.
// Takes one item at a time (key press, server response, millisecond tick or
// network status) and returns one result item with the phase and the entered
// id and PIN. An item passes the execute state; for a tick in the locked phase
// it then passes the divide and lock states, with a reciprocal multiply for the
// seconds split; then the start and fold states, where the digit fold unit walks
// the id and PIN buffers one digit per cycle; then the emit state, which waits
// while the output register holds a result that is not being taken. A finished
// result waits in the output register while the next item is taken. Configuration
// is written through a plain write port by the user only while no item is open; the block does not enforce this.
module keypad_pin_auth_sequencer_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [1:0]                      i_cfg_index,
    input  logic [kpas_pkg::CFG_W-1:0]      i_cfg_wr_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_operation,
    input  logic [7:0]                      i_key_code,
    input  logic [2:0]                      i_response_status,
    input  logic [7:0]                      i_response_attempts,
    input  logic [15:0]                     i_response_lockout_s,
    input  logic [15:0]                     i_elapsed_ms,
    input  logic                            i_link_up,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [2:0]                      o_phase,
    output logic                            o_request_auth,
    output logic [kpas_pkg::ID_VALUE_W-1:0] o_user_id_value,
    output logic [kpas_pkg::COUNT_W-1:0]    o_user_id_count,
    output logic [kpas_pkg::PIN_BCD_W-1:0]  o_pin_bcd,
    output logic [kpas_pkg::COUNT_W-1:0]    o_pin_count,
    output logic [7:0]                      o_attempts_left,
    output logic [15:0]                     o_lockout_left_s,
    output logic                            o_network_ok
);
    import kpas_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_LOCK  = 7'b0001000,
        S_START = 7'b0010000,
        S_FOLD  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_seq_state;

    t_seq_state r_state, n_state;

    logic [CFG_W-1:0]     r_auth_ms;
    logic [CFG_W-1:0]     r_success_ms;
    logic [CFG_W-1:0]     r_message_ms;

    t_item                r_item;
    t_phase               r_phase, n_phase;
    logic [ID_LEN_W-1:0]  r_id_len, n_id_len;
    logic [PIN_LEN_W-1:0] r_pin_len, n_pin_len;
    logic                 r_link, n_link;
    logic [7:0]           r_attempts, n_attempts;
    logic [15:0]          r_lock, n_lock;
    logic [TIMER_W-1:0]   r_timer, n_timer;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic                 r_req, n_req;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [PROD_W-1:0]    r_prod;
    logic                 r_out_valid;

    t_digit               r_id_digits [ID_DIGITS];
    t_digit               r_pin_digits [PIN_DIGITS];

    logic                 id_wr;
    logic                 pin_wr;
    logic                 clr;
    logic                 is_digit;
    logic [TIMER_W-1:0]   timer_sum;
    logic [SECS_W-1:0]    secs;
    logic [SUM_W-1:0]     rem;
    logic [15:0]          lock_next;
    logic                 out_load;

    logic [FOLD_W-1:0]     fold_idx;
    t_fold_stat            fold_stat;
    logic [ID_VALUE_W-1:0] fold_idv;
    logic [PIN_BCD_W-1:0]  fold_pinv;
    t_digit                fold_id_digit;
    t_digit                fold_pin_digit;

    assign o_in_ready = r_state == S_IDLE;
    assign out_load   = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    assign is_digit   = r_item.key inside {[KEY_ZERO:KEY_NINE]};
    assign timer_sum  = r_timer + TIMER_W'(r_item.elapsed);
    assign secs       = r_prod[DIV_SHIFT+SECS_W-1:DIV_SHIFT];
    assign rem        = r_sum - (SUM_W'(secs) * SUM_W'(MS_PER_S));
    assign lock_next  = ({8'b0, secs} >= r_lock) ? 16'd0 : r_lock - {8'b0, secs};

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_id_len   = r_id_len;
        n_pin_len  = r_pin_len;
        n_link     = r_link;
        n_attempts = r_attempts;
        n_lock     = r_lock;
        n_timer    = r_timer;
        n_acc      = r_acc;
        n_req      = r_req;
        n_sum      = r_sum;
        id_wr      = 1'b0;
        pin_wr     = 1'b0;
        clr        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_req   = 1'b0;
                n_state = S_START;
                case (r_item.op)
                    OP_KEY: begin
                        case (r_phase)
                            PH_ID: begin
                                if (is_digit) begin
                                    if (r_id_len < ID_LEN_W'(ID_DIGITS)) begin
                                        id_wr    = 1'b1;
                                        n_id_len = r_id_len + 1'b1;
                                    end
                                end else if (r_item.key == KEY_STAR) begin
                                    if (r_id_len != '0) begin
                                        n_id_len = r_id_len - 1'b1;
                                    end
                                end else if (r_item.key == KEY_HASH) begin
                                    if (r_id_len != '0) begin
                                        n_phase   = PH_PIN;
                                        n_pin_len = '0;
                                    end
                                end
                            end
                            PH_PIN: begin
                                if (is_digit) begin
                                    if (r_pin_len < PIN_LEN_W'(PIN_DIGITS)) begin
                                        pin_wr    = 1'b1;
                                        n_pin_len = r_pin_len + 1'b1;
                                    end
                                end else if (r_item.key == KEY_STAR) begin
                                    if (r_pin_len != '0) begin
                                        n_pin_len = r_pin_len - 1'b1;
                                    end else begin
                                        n_phase = PH_ID;
                                    end
                                end else if (r_item.key == KEY_HASH && r_pin_len != '0) begin
                                    if (!r_link) begin
                                        n_phase = PH_OFFLINE;
                                        n_timer = '0;
                                    end else begin
                                        n_phase = PH_AUTH;
                                        n_req   = 1'b1;
                                    end
                                end
                            end
                            PH_AUTH: begin
                                if (r_item.key == KEY_STAR) begin
                                    n_phase = PH_PIN;
                                    n_timer = '0;
                                end
                            end
                            PH_OFFLINE: begin
                                n_phase = PH_PIN;
                            end
                            default: begin
                            end
                        endcase
                    end
                    OP_RESP: begin
                        if (r_phase == PH_AUTH) begin
                            n_timer = '0;
                            n_acc   = '0;
                            case (r_item.status)
                                ST_OK: begin
                                    n_phase = PH_SUCCESS;
                                end
                                ST_BAD_PIN: begin
                                    n_phase    = PH_BAD_PIN;
                                    n_attempts = r_item.attempts;
                                end
                                ST_LOCKED: begin
                                    n_phase = PH_LOCKED;
                                    n_lock  = r_item.lock_s;
                                end
                                ST_NOTFND: begin
                                    n_phase = PH_NOTFND;
                                end
                                default: begin
                                    n_phase = PH_ID;
                                end
                            endcase
                        end
                    end
                    OP_TICK: begin
                        n_timer = timer_sum;
                        case (r_phase)
                            PH_AUTH: begin
                                if (timer_sum >= TIMER_W'(r_auth_ms)) begin
                                    n_phase = PH_OFFLINE;
                                    n_timer = '0;
                                end
                            end
                            PH_SUCCESS: begin
                                if (timer_sum >= TIMER_W'(r_success_ms)) begin
                                    clr = 1'b1;
                                end
                            end
                            PH_BAD_PIN: begin
                                if (timer_sum >= TIMER_W'(r_message_ms)) begin
                                    n_phase   = PH_PIN;
                                    n_pin_len = '0;
                                    n_timer   = '0;
                                end
                            end
                            PH_LOCKED: begin
                                n_sum   = SUM_W'(r_acc) + SUM_W'(r_item.elapsed);
                                n_state = S_DIV;
                            end
                            PH_NOTFND: begin
                                if (timer_sum >= TIMER_W'(r_message_ms)) begin
                                    clr = 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    OP_LINK: begin
                        n_link = r_item.link;
                    end
                    default: begin
                    end
                endcase
            end
            S_DIV: begin
                n_state = S_LOCK;
            end
            S_LOCK: begin
                n_acc   = rem[ACC_W-1:0];
                n_lock  = lock_next;
                n_state = S_START;
                if (lock_next == 16'd0) begin
                    clr = 1'b1;
                end
            end
            S_START: begin
                n_state = S_FOLD;
            end
            S_FOLD: begin
                if (fold_stat.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (clr) begin
            n_phase    = PH_ID;
            n_id_len   = '0;
            n_pin_len  = '0;
            n_link     = 1'b1;
            n_attempts = '0;
            n_lock     = '0;
            n_timer    = '0;
            n_acc      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_auth_ms    <= 16'd10000;
            r_success_ms <= 16'd3000;
            r_message_ms <= 16'd3000;
            r_phase      <= PH_ID;
            r_id_len     <= '0;
            r_pin_len    <= '0;
            r_link       <= 1'b1;
            r_attempts   <= '0;
            r_lock       <= '0;
            r_timer      <= '0;
            r_acc        <= '0;
            r_req        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_id_len   <= n_id_len;
            r_pin_len  <= n_pin_len;
            r_link     <= n_link;
            r_attempts <= n_attempts;
            r_lock     <= n_lock;
            r_timer    <= n_timer;
            r_acc      <= n_acc;
            r_req      <= n_req;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_AUTH_TIMEOUT: r_auth_ms    <= i_cfg_wr_data;
                    CFG_SUCCESS_SHOW: r_success_ms <= i_cfg_wr_data;
                    CFG_MESSAGE_SHOW: r_message_ms <= i_cfg_wr_data;
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.op       <= t_op'(i_operation);
            r_item.key      <= i_key_code;
            r_item.status   <= i_response_status;
            r_item.attempts <= i_response_attempts;
            r_item.lock_s   <= i_response_lockout_s;
            r_item.elapsed  <= i_elapsed_ms;
            r_item.link     <= i_link_up;
        end
        if (id_wr) begin
            r_id_digits[r_id_len[ID_IDX_W-1:0]] <= r_item.key[DIGIT_W-1:0];
        end
        if (pin_wr) begin
            r_pin_digits[r_pin_len[PIN_IDX_W-1:0]] <= r_item.key[DIGIT_W-1:0];
        end
        r_sum  <= n_sum;
        r_prod <= PROD_W'(r_sum) * PROD_W'(DIV_RECIP);
        if (out_load) begin
            o_phase          <= r_phase;
            o_request_auth   <= r_req;
            o_user_id_value  <= fold_idv;
            o_user_id_count  <= COUNT_W'(r_id_len);
            o_pin_bcd        <= fold_pinv;
            o_pin_count      <= COUNT_W'(r_pin_len);
            o_attempts_left  <= r_attempts;
            o_lockout_left_s <= r_lock;
            o_network_ok     <= r_link;
        end
    end

    assign fold_id_digit  = r_id_digits[fold_idx[ID_IDX_W-1:0]];
    assign fold_pin_digit = r_pin_digits[fold_idx[PIN_IDX_W-1:0]];
    assign o_out_valid    = r_out_valid;

    kpas_fold u_fold (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_state == S_START),
        .i_id_len    (r_id_len),
        .i_pin_len   (r_pin_len),
        .i_id_digit  (fold_id_digit),
        .i_pin_digit (fold_pin_digit),
        .o_idx       (fold_idx),
        .o_stat      (fold_stat),
        .o_id_value  (fold_idv),
        .o_pin_bcd   (fold_pinv)
    );

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EXEC))
        else $error("accepted item did not start execution");

    a_req_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_request_auth) |-> (o_phase == PH_AUTH))
        else $error("auth request outside authenticating phase");

    a_fold_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fold_stat.done |-> (r_state == S_FOLD))
        else $error("fold finished outside fold state");

    a_emit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_out_valid && r_state == S_IDLE))
        else $error("emitted item not presented");

endmodule

FILE: tb/keypad_pin_auth_sequencer_checker.sv
`timescale 1ns / 100ps
// Result checker for the keypad PIN sequencer: tracks the terminal and compares each result item.
module keypad_pin_auth_sequencer_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [1:0]                      i_cfg_index,
    input  logic [kpas_pkg::CFG_W-1:0]      i_cfg_wr_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [1:0]                      i_operation,
    input  logic [7:0]                      i_key_code,
    input  logic [2:0]                      i_response_status,
    input  logic [7:0]                      i_response_attempts,
    input  logic [15:0]                     i_response_lockout_s,
    input  logic [15:0]                     i_elapsed_ms,
    input  logic                            i_link_up,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [2:0]                      i_phase,
    input  logic                            i_request_auth,
    input  logic [kpas_pkg::ID_VALUE_W-1:0] i_user_id_value,
    input  logic [kpas_pkg::COUNT_W-1:0]    i_user_id_count,
    input  logic [kpas_pkg::PIN_BCD_W-1:0]  i_pin_bcd,
    input  logic [kpas_pkg::COUNT_W-1:0]    i_pin_count,
    input  logic [7:0]                      i_attempts_left,
    input  logic [15:0]                     i_lockout_left_s,
    input  logic                            i_network_ok,
    output int                              o_fail_count,
    output int                              o_pending,
    output kpas_pkg::t_phase                o_model_phase
);
    import kpas_pkg::*;

    localparam logic [CFG_W-1:0] AUTH_TIMEOUT_RST = 16'd10000;
    localparam logic [CFG_W-1:0] SHOW_RST         = 16'd3000;

    typedef struct packed {
        t_phase                phase;
        logic                  req;
        logic [ID_VALUE_W-1:0] id_value;
        logic [COUNT_W-1:0]    id_count;
        logic [PIN_BCD_W-1:0]  pin_bcd;
        logic [COUNT_W-1:0]    pin_count;
        logic [7:0]            attempts;
        logic [15:0]           lockout;
        logic                  link;
    } t_terminal_view;

    logic [CFG_W-1:0]   auth_timeout;
    logic [CFG_W-1:0]   success_show;
    logic [CFG_W-1:0]   message_show;
    t_phase             phase_now;
    t_digit             id_buf [ID_DIGITS];
    logic [COUNT_W-1:0] id_len;
    t_digit             pin_buf [PIN_DIGITS];
    logic [COUNT_W-1:0] pin_len;
    logic               link_ok;
    logic [7:0]         attempts;
    logic [15:0]        lock_left;
    logic [TIMER_W-1:0] elapsed;
    logic [ACC_W-1:0]   sec_acc;
    t_terminal_view     pending_views [$];
    int                 mismatches = 0;

    task automatic clear_session();
        int i;
        for (i = 0; i < ID_DIGITS; i++) id_buf[i] = '0;
        for (i = 0; i < PIN_DIGITS; i++) pin_buf[i] = '0;
        phase_now = PH_ID;
        id_len    = '0;
        pin_len   = '0;
        link_ok   = 1'b1;
        attempts  = '0;
        lock_left = '0;
        elapsed   = '0;
        sec_acc   = '0;
    endtask

    task automatic press_key(input logic [7:0] key, output logic starts_auth);
        logic is_digit;
        is_digit = (key >= KEY_ZERO) && (key <= KEY_NINE);
        starts_auth = 1'b0;
        case (phase_now)
            PH_ID: begin
                if (is_digit) begin
                    if (id_len < ID_DIGITS) begin
                        id_buf[id_len] = t_digit'(key - KEY_ZERO);
                        id_len = id_len + 1'b1;
                    end
                end else if (key == KEY_STAR) begin
                    if (id_len > 0) id_len = id_len - 1'b1;
                end else if (key == KEY_HASH) begin
                    if (id_len > 0) begin
                        phase_now = PH_PIN;
                        pin_len = '0;
                    end
                end
            end
            PH_PIN: begin
                if (is_digit) begin
                    if (pin_len < PIN_DIGITS) begin
                        pin_buf[pin_len] = t_digit'(key - KEY_ZERO);
                        pin_len = pin_len + 1'b1;
                    end
                end else if (key == KEY_STAR) begin
                    if (pin_len > 0) pin_len = pin_len - 1'b1;
                    else phase_now = PH_ID;
                end else if (key == KEY_HASH && pin_len > 0) begin
                    if (!link_ok) begin
                        phase_now = PH_OFFLINE;
                        elapsed = '0;
                    end else begin
                        phase_now = PH_AUTH;
                        starts_auth = 1'b1;
                    end
                end
            end
            PH_AUTH: begin
                if (key == KEY_STAR) begin
                    phase_now = PH_PIN;
                    elapsed = '0;
                end
            end
            PH_OFFLINE: phase_now = PH_PIN;
            default: ;
        endcase
    endtask

    task automatic take_response(input logic [2:0] status, input logic [7:0] att,
                                 input logic [15:0] lock_s);
        if (phase_now == PH_AUTH) begin
            elapsed = '0;
            sec_acc = '0;
            case (status)
                ST_OK: phase_now = PH_SUCCESS;
                ST_BAD_PIN: begin
                    phase_now = PH_BAD_PIN;
                    attempts = att;
                end
                ST_LOCKED: begin
                    phase_now = PH_LOCKED;
                    lock_left = lock_s;
                end
                ST_NOTFND: phase_now = PH_NOTFND;
                default: phase_now = PH_ID;
            endcase
        end
    endtask

    task automatic advance_time(input logic [15:0] ms);
        logic [16:0] total;
        logic [16:0] whole_s;
        elapsed = elapsed + TIMER_W'(ms);
        case (phase_now)
            PH_AUTH: begin
                if (elapsed >= TIMER_W'(auth_timeout)) begin
                    phase_now = PH_OFFLINE;
                    elapsed = '0;
                end
            end
            PH_SUCCESS: if (elapsed >= TIMER_W'(success_show)) clear_session();
            PH_BAD_PIN: begin
                if (elapsed >= TIMER_W'(message_show)) begin
                    phase_now = PH_PIN;
                    pin_len = '0;
                    elapsed = '0;
                end
            end
            PH_LOCKED: begin
                total   = 17'(sec_acc) + 17'(ms);
                whole_s = total / 17'(MS_PER_S);
                sec_acc = ACC_W'(total % 17'(MS_PER_S));
                if (whole_s >= 17'(lock_left)) lock_left = '0;
                else lock_left = lock_left - 16'(whole_s);
                if (lock_left == '0) clear_session();
            end
            PH_NOTFND: if (elapsed >= TIMER_W'(message_show)) clear_session();
            default: ;
        endcase
    endtask

    function automatic t_terminal_view snapshot(input logic req);
        t_terminal_view v;
        logic [31:0] idv;
        logic [31:0] pinv;
        int i;
        idv = '0;
        pinv = '0;
        for (i = 0; i < ID_DIGITS; i++) begin
            if (i < id_len) idv = idv * 10 + 32'(id_buf[i]);
        end
        for (i = 0; i < PIN_DIGITS; i++) begin
            if (i < pin_len) pinv = (pinv << DIGIT_W) | 32'(pin_buf[i]);
        end
        v.phase     = phase_now;
        v.req       = req;
        v.id_value  = ID_VALUE_W'(idv);
        v.id_count  = id_len;
        v.pin_bcd   = pinv;
        v.pin_count = pin_len;
        v.attempts  = attempts;
        v.lockout   = lock_left;
        v.link      = link_ok;
        return v;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : track
        t_terminal_view want;
        logic req;
        if (!i_rst_n) begin
            auth_timeout = AUTH_TIMEOUT_RST;
            success_show = SHOW_RST;
            message_show = SHOW_RST;
            clear_session();
            pending_views.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_AUTH_TIMEOUT: auth_timeout = i_cfg_wr_data;
                    CFG_SUCCESS_SHOW: success_show = i_cfg_wr_data;
                    CFG_MESSAGE_SHOW: message_show = i_cfg_wr_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                req = 1'b0;
                case (t_op'(i_operation))
                    OP_KEY:  press_key(i_key_code, req);
                    OP_RESP: take_response(i_response_status, i_response_attempts,
                                           i_response_lockout_s);
                    OP_TICK: advance_time(i_elapsed_ms);
                    default: link_ok = i_link_up;
                endcase
                pending_views.push_back(snapshot(req));
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_views.size() == 0) begin
                    mismatches++;
                    $error("result item arrived with nothing expected");
                end else begin
                    want = pending_views.pop_front();
                    check_field("phase", 32'(want.phase), 32'(i_phase));
                    check_field("request_auth", 32'(want.req), 32'(i_request_auth));
                    check_field("user_id_value", 32'(want.id_value), 32'(i_user_id_value));
                    check_field("user_id_count", 32'(want.id_count), 32'(i_user_id_count));
                    check_field("pin_bcd", want.pin_bcd, i_pin_bcd);
                    check_field("pin_count", 32'(want.pin_count), 32'(i_pin_count));
                    check_field("attempts_left", 32'(want.attempts), 32'(i_attempts_left));
                    check_field("lockout_left_s", 32'(want.lockout), 32'(i_lockout_left_s));
                    check_field("network_ok", 32'(want.link), 32'(i_network_ok));
                end
            end
        end
        o_pending     <= pending_views.size();
        o_fail_count  <= mismatches;
        o_model_phase <= phase_now;
    end

endmodule

FILE: tb/keypad_pin_auth_sequencer_top_test.sv
`timescale 1ns / 100ps
// Testbench top for the keypad PIN sequencer: clock, reset, stimulus and verdict.
module keypad_pin_auth_sequencer_top_test;
    import kpas_pkg::*;

    localparam int CYCLE_LIMIT       = 600000;
    localparam int SETTLE_CYCLES     = 20;
    localparam int DRAIN_CYCLES      = 40;
    localparam int ITEMS_PER_SETTING = 125;
    localparam int SETTINGS_COUNT    = 6;
    localparam int HOME_TRIES        = 40;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [1:0]            cfg_index = CFG_AUTH_TIMEOUT;
    logic [CFG_W-1:0]      cfg_wr_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [1:0]            operation = OP_TICK;
    logic [7:0]            key_code = '0;
    logic [2:0]            response_status = '0;
    logic [7:0]            response_attempts = '0;
    logic [15:0]           response_lockout_s = '0;
    logic [15:0]           elapsed_ms = '0;
    logic                  link_up = 1'b1;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [2:0]            phase;
    logic                  request_auth;
    logic [ID_VALUE_W-1:0] user_id_value;
    logic [COUNT_W-1:0]    user_id_count;
    logic [PIN_BCD_W-1:0]  pin_bcd;
    logic [COUNT_W-1:0]    pin_count;
    logic [7:0]            attempts_left;
    logic [15:0]           lockout_left_s;
    logic                  network_ok;

    int     fail_count;
    int     pending;
    t_phase model_phase;
    int     cycle_count = 0;
    int     rx_count = 0;
    int     burst_left = 0;
    bit     steady = 1'b0;
    int     items_sent = 0;

    keypad_pin_auth_sequencer_top uut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_wr_en          (cfg_wr_en),
        .i_cfg_index          (cfg_index),
        .i_cfg_wr_data        (cfg_wr_data),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_operation          (operation),
        .i_key_code           (key_code),
        .i_response_status    (response_status),
        .i_response_attempts  (response_attempts),
        .i_response_lockout_s (response_lockout_s),
        .i_elapsed_ms         (elapsed_ms),
        .i_link_up            (link_up),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_phase              (phase),
        .o_request_auth       (request_auth),
        .o_user_id_value      (user_id_value),
        .o_user_id_count      (user_id_count),
        .o_pin_bcd            (pin_bcd),
        .o_pin_count          (pin_count),
        .o_attempts_left      (attempts_left),
        .o_lockout_left_s     (lockout_left_s),
        .o_network_ok         (network_ok)
    );

    keypad_pin_auth_sequencer_checker result_check (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_wr_en          (cfg_wr_en),
        .i_cfg_index          (cfg_index),
        .i_cfg_wr_data        (cfg_wr_data),
        .i_in_valid           (in_valid),
        .i_in_ready           (in_ready),
        .i_operation          (operation),
        .i_key_code           (key_code),
        .i_response_status    (response_status),
        .i_response_attempts  (response_attempts),
        .i_response_lockout_s (response_lockout_s),
        .i_elapsed_ms         (elapsed_ms),
        .i_link_up            (link_up),
        .i_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .i_phase              (phase),
        .i_request_auth       (request_auth),
        .i_user_id_value      (user_id_value),
        .i_user_id_count      (user_id_count),
        .i_pin_bcd            (pin_bcd),
        .i_pin_count          (pin_count),
        .i_attempts_left      (attempts_left),
        .i_lockout_left_s     (lockout_left_s),
        .i_network_ok         (network_ok),
        .o_fail_count         (fail_count),
        .o_pending            (pending),
        .o_model_phase        (model_phase)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk) begin
        rx_count <= rx_count + 1;
        case (rx_count[10:8])
            3'd0, 3'd1: out_ready <= 1'b1;
            3'd2:       out_ready <= 1'($urandom_range(0, 1));
            3'd3:       out_ready <= ($urandom_range(0, 3) == 0);
            3'd4:       out_ready <= (rx_count[4:0] >= 5'd24);
            3'd5:       out_ready <= ($urandom_range(0, 3) != 0);
            default:    out_ready <= rx_count[1];
        endcase
    end

    task automatic send(input t_op op, input logic [7:0] key, input logic [2:0] status,
                        input logic [7:0] att, input logic [15:0] lock_s,
                        input logic [15:0] ms, input logic link);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (steady) gap = 0;
            else if ($urandom_range(0, 3) == 0) gap = $urandom_range(6, 40);
            else gap = $urandom_range(0, 4);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        operation          <= op;
        key_code           <= key;
        response_status    <= status;
        response_attempts  <= att;
        response_lockout_s <= lock_s;
        elapsed_ms         <= ms;
        link_up            <= link;
        in_valid           <= 1'b1;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic press(input logic [7:0] key);
        send(OP_KEY, key, 3'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
             1'($urandom));
    endtask

    task automatic respond(input logic [2:0] status, input logic [7:0] att,
                           input logic [15:0] lock_s);
        send(OP_RESP, 8'($urandom), status, att, lock_s, 16'($urandom), 1'($urandom));
    endtask

    task automatic tick(input logic [15:0] ms);
        send(OP_TICK, 8'($urandom), 3'($urandom), 8'($urandom), 16'($urandom), ms,
             1'($urandom));
    endtask

    task automatic set_link(input logic up);
        send(OP_LINK, 8'($urandom), 3'($urandom), 8'($urandom), 16'($urandom),
             16'($urandom), up);
    endtask

    function automatic logic [7:0] digit_key();
        return KEY_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] any_key();
        case ($urandom_range(0, 5))
            0:       return KEY_STAR;
            1:       return KEY_HASH;
            2, 3:    return digit_key();
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_ms();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 999));
            1:       return 16'($urandom_range(1000, 4000));
            2:       return 16'($urandom_range(0, 12000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_lockout();
        if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 3));
        return 16'($urandom_range(0, 400));
    endfunction

    function automatic logic [2:0] pick_status();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 5) return ST_OK;
        if (roll < 10) return ST_BAD_PIN;
        if (roll < 14) return ST_LOCKED;
        if (roll < 17) return ST_NOTFND;
        return 3'($urandom_range(4, 7));
    endfunction

    task automatic peek_phase(output t_phase ph);
        in_valid <= 1'b0;
        @(posedge clk);
        ph = model_phase;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_timeouts(input logic [15:0] auth_ms, input logic [15:0] success_ms,
                                input logic [15:0] message_ms);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_AUTH_TIMEOUT;
        cfg_wr_data <= auth_ms;
        @(posedge clk);
        cfg_index   <= CFG_SUCCESS_SHOW;
        cfg_wr_data <= success_ms;
        @(posedge clk);
        cfg_index   <= CFG_MESSAGE_SHOW;
        cfg_wr_data <= message_ms;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // steer the terminal back to id entry before a new login attempt
    task automatic go_home();
        t_phase ph;
        int tries;
        bit home;
        tries = 0;
        home = 1'b0;
        while (!home && tries < HOME_TRIES) begin
            peek_phase(ph);
            case (ph)
                PH_ID:      home = 1'b1;
                PH_PIN:     press(KEY_STAR);
                PH_AUTH: begin
                    if ($urandom_range(0, 1) == 0) press(KEY_STAR);
                    else respond(pick_status(), 8'($urandom), pick_lockout());
                end
                PH_OFFLINE: press(any_key());
                default:    tick(16'hFFFF);
            endcase
            tries++;
        end
    endtask

    task automatic run_session();
        int n;
        int i;
        go_home();
        if ($urandom_range(0, 4) == 0) set_link(1'b0);
        else if ($urandom_range(0, 4) == 0) set_link(1'b1);
        repeat ($urandom_range(0, 3)) press(KEY_STAR);
        n = $urandom_range(1, 10);
        for (i = 0; i < n; i++) begin
            press(digit_key());
            if ($urandom_range(0, 9) == 0) press(KEY_STAR);
            if ($urandom_range(0, 19) == 0) press(8'($urandom));
        end
        press(KEY_HASH);
        if ($urandom_range(0, 9) == 0) press(KEY_STAR);
        n = $urandom_range(0, 10);
        for (i = 0; i < n; i++) begin
            press(digit_key());
            if ($urandom_range(0, 9) == 0) press(KEY_STAR);
        end
        press(KEY_HASH);
        case ($urandom_range(0, 9))
            0:       repeat ($urandom_range(1, 4)) tick(pick_ms());
            1:       press(KEY_STAR);
            2:       press(any_key());
            default: respond(pick_status(), 8'($urandom), pick_lockout());
        endcase
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 5))
                0:       press(any_key());
                1:       respond(pick_status(), 8'($urandom), pick_lockout());
                default: tick(pick_ms());
            endcase
        end
    endtask

    task automatic run_noise();
        repeat ($urandom_range(3, 10)) begin
            send(t_op'($urandom_range(0, 3)), any_key(), 3'($urandom), 8'($urandom),
                 pick_lockout(), pick_ms(), 1'($urandom));
        end
    endtask

    initial begin
        int setting;
        int target;
        int i;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        steady = 1'b1;
        press(KEY_STAR);
        press(KEY_HASH);
        press(8'hFF);
        for (i = 0; i < ID_DIGITS + 1; i++) press((i % 2) ? KEY_ZERO : KEY_NINE);
        press(KEY_STAR);
        press(KEY_HASH);
        press(KEY_STAR);
        press(KEY_HASH);
        press(KEY_ZERO);
        press(KEY_NINE);
        tick(16'h0000);
        press(KEY_HASH);
        press(digit_key());
        press(KEY_STAR);
        set_link(1'b0);
        press(KEY_HASH);
        press(8'h00);
        set_link(1'b1);
        press(KEY_HASH);
        respond(ST_BAD_PIN, 8'hFF, 16'hFFFF);
        tick(16'hFFFF);
        press(KEY_HASH);
        steady = 1'b0;

        for (setting = 0; setting < SETTINGS_COUNT; setting++) begin
            wait_idle();
            case (setting)
                1:       set_timeouts(16'd0, 16'd0, 16'd0);
                2:       set_timeouts(16'hFFFF, 16'hFFFF, 16'hFFFF);
                3:       set_timeouts(16'($urandom), 16'($urandom), 16'($urandom));
                4:       set_timeouts(16'd1, 16'hFFFF, 16'd0);
                5:       set_timeouts(16'd500, 16'd1000, 16'd250);
                default: ;
            endcase
            target = items_sent + ITEMS_PER_SETTING;
            while (items_sent < target) begin
                steady = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 3) == 0) run_noise();
                else run_session();
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: keypad_pin_auth_sequencer_top.f
src/kpas_pkg.sv
src/kpas_fold.sv
src/keypad_pin_auth_sequencer_top.sv
tb/keypad_pin_auth_sequencer_checker.sv
tb/keypad_pin_auth_sequencer_top_test.sv
